// ===== src/pbrd_pkg.sv =====
// pbrd_pkg: types and constants shared by the packbits raster decoder files
// no dependencies

package pbrd_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [BYTE_W-1:0] NOOP_CODE = 8'h80;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKED_MODE  = 2'd2;

  localparam logic [COORD_W-1:0] WIDTH_RESET  = 16'd320;
  localparam logic [COORD_W-1:0] HEIGHT_RESET = 16'd200;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_LIT  = 2'd1,
    PH_FILL = 2'd2
  } phase_t;

  typedef struct packed {
    logic [COORD_W-1:0] image_width;
    logic [COORD_W-1:0] image_height;
    logic               packed_mode;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [BYTE_W-1:0]  literal_left;
    logic [BYTE_W-1:0]  fill_count;
    logic [COORD_W-1:0] column_pos;
    logic [COORD_W-1:0] row_pos;
    logic               finished;
  } dec_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_column;
    logic [COORD_W-1:0] pixel_row;
    logic [BYTE_W-1:0]  pixel_color;
    logic [BYTE_W-1:0]  run_length;
    logic               image_done;
    logic               row_overrun;
  } pixel_t;

endpackage

// ===== src/pbrd_if.sv =====
// pbrd_in_if / pbrd_out_if: valid/ready channels of the packbits raster decoder
// depends on pbrd_pkg for field widths

interface pbrd_in_if;
  logic                        valid;
  logic                        ready;
  logic [pbrd_pkg::BYTE_W-1:0] body_byte;
  logic                        image_start;

  modport source (output valid, output body_byte, output image_start, input ready);
  modport sink (input valid, input body_byte, input image_start, output ready);
endinterface

interface pbrd_out_if;
  logic                         valid;
  logic                         ready;
  logic [pbrd_pkg::COORD_W-1:0] pixel_column;
  logic [pbrd_pkg::COORD_W-1:0] pixel_row;
  logic [pbrd_pkg::BYTE_W-1:0]  pixel_color;
  logic [pbrd_pkg::BYTE_W-1:0]  run_length;
  logic                         image_done;
  logic                         row_overrun;

  modport source (output valid, output pixel_column, output pixel_row, output pixel_color,
                  output run_length, output image_done, output row_overrun, input ready);
  modport sink (input valid, input pixel_column, input pixel_row, input pixel_color,
                input run_length, input image_done, input row_overrun, output ready);
endinterface

// ===== src/packbits_raster_decoder_unit.sv =====
// packbits_raster_decoder_unit: packbits body decoder to row/column pixel writes
// depends on pbrd_pkg, pbrd_in_if, pbrd_out_if and pbrd_step
//
//   channel  dir  payload                                          handshake
//   body     in   body_byte, image_start                           valid/ready
//   pixels   out  pixel_column, pixel_row, pixel_color,            valid/ready
//                 run_length, image_done, row_overrun
//   cfg      in   cfg_index, cfg_data                              cfg_write
//
// one byte per cycle; a byte is decoded in the cycle it is taken and its pixel
// write shows up in the output register on the next cycle
// body.ready drops while a pixel write waits in the output register and the pixels
// sink is not ready, whether or not the next byte would write anything
// synchronous reset clears decoder state and the output valid, and loads the
// default width 320, height 200 and packed mode

module packbits_raster_decoder_unit (
  input  logic                            clk,
  input  logic                            rst,
  pbrd_in_if.sink                         body,
  pbrd_out_if.source                      pixels,
  input  logic                            cfg_write,
  input  logic [pbrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbrd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pbrd_pkg::*;

  cfg_t       cfg;
  dec_state_t state;
  dec_state_t state_next;
  logic       step_emit;
  pixel_t     step_pixel;
  pixel_t     out_reg;
  logic       out_valid;
  logic       accept;

  assign body.ready = !out_valid || pixels.ready;
  assign accept     = body.valid && body.ready;

  pbrd_step u_step (
    .cfg         (cfg),
    .state       (state),
    .body_byte   (body.body_byte),
    .image_start (body.image_start),
    .state_next  (state_next),
    .emit        (step_emit),
    .pixel       (step_pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= WIDTH_RESET;
      cfg.image_height <= HEIGHT_RESET;
      cfg.packed_mode  <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        CFG_PACKED_MODE:  cfg.packed_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_CTRL, default: '0};
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && step_emit) begin
      out_valid <= 1'b1;
    end else if (pixels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step_emit) begin
      out_reg <= step_pixel;
    end
  end

  assign pixels.valid        = out_valid;
  assign pixels.pixel_column = out_reg.pixel_column;
  assign pixels.pixel_row    = out_reg.pixel_row;
  assign pixels.pixel_color  = out_reg.pixel_color;
  assign pixels.run_length   = out_reg.run_length;
  assign pixels.image_done   = out_reg.image_done;
  assign pixels.row_overrun  = out_reg.row_overrun;

  a_emit_loads_output: assert property (@(posedge clk) disable iff (rst)
    accept && step_emit |=> out_valid)
    else $error("pixel write lost after decode");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_reg.run_length != '0)
    else $error("pixel write with zero run length");

  a_overrun_hits_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.row_overrun |->
      ({1'b0, out_reg.pixel_column} + {9'd0, out_reg.run_length}) == {1'b0, cfg.image_width})
    else $error("clipped fill does not end at row end");

  a_literal_count_live: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_LIT |-> state.literal_left != '0)
    else $error("literal phase with no bytes left");

  a_finished_holds: assert property (@(posedge clk) disable iff (rst)
    state.finished && !(accept && body.image_start) |=>
      $stable(state.row_pos) && $stable(state.column_pos) && state.finished)
    else $error("position moved after last row");

endmodule

// ===== src/pbrd_step.sv =====
// pbrd_step: decode of one body byte, next decoder state and pixel write
// depends on pbrd_pkg

module pbrd_step (
  input  pbrd_pkg::cfg_t                cfg,
  input  pbrd_pkg::dec_state_t          state,
  input  logic [pbrd_pkg::BYTE_W-1:0]   body_byte,
  input  logic                          image_start,
  output pbrd_pkg::dec_state_t          state_next,
  output logic                          emit,
  output pbrd_pkg::pixel_t              pixel
);
  import pbrd_pkg::*;

  dec_state_t         cur;
  logic               blocked;
  logic               col_in_row;
  logic [COORD_W-1:0] room;
  logic [BYTE_W-1:0]  fill_fit;
  logic [BYTE_W-1:0]  count;
  logic               overrun;
  logic               pkt_end;
  logic [COORD_W:0]   col_end;
  logic [COORD_W-1:0] col_after;
  logic [COORD_W:0]   row_plus;

  // a new image clears position and phase before the byte is decoded
  always_comb begin
    cur = state;
    if (image_start) begin
      cur.phase        = PH_CTRL;
      cur.literal_left = '0;
      cur.fill_count   = '0;
      cur.column_pos   = '0;
      cur.row_pos      = '0;
      cur.finished     = 1'b0;
    end
  end

  assign blocked    = cur.finished || (cur.row_pos >= cfg.image_height);
  assign col_in_row = cur.column_pos < cfg.image_width;
  assign room       = col_in_row ? (cfg.image_width - cur.column_pos) : '0;
  assign fill_fit   = ({8'd0, cur.fill_count} < room) ? cur.fill_count : room[BYTE_W-1:0];

  // what this byte writes and whether it closes a packet
  always_comb begin
    emit    = 1'b0;
    count   = 8'd1;
    overrun = 1'b0;
    pkt_end = 1'b0;
    if (!blocked) begin
      if (!cfg.packed_mode) begin
        emit    = col_in_row;
        pkt_end = 1'b1;
      end else begin
        unique case (cur.phase)
          PH_LIT: begin
            emit    = col_in_row;
            pkt_end = (cur.literal_left == 8'd1);
          end
          PH_FILL: begin
            count   = fill_fit;
            emit    = (fill_fit != '0);
            overrun = (fill_fit < cur.fill_count);
            pkt_end = 1'b1;
          end
          default: begin
            pkt_end = (body_byte == NOOP_CODE);
          end
        endcase
      end
    end
  end

  assign col_end   = {1'b0, cur.column_pos} + {9'd0, count};
  assign col_after = emit ? col_end[COORD_W-1:0] : cur.column_pos;
  assign row_plus  = {1'b0, cur.row_pos} + 17'd1;

  // next state
  always_comb begin
    state_next = cur;
    if (blocked) begin
      state_next.finished = 1'b1;
    end else begin
      if (!cfg.packed_mode) begin
        state_next.phase = PH_CTRL;
      end else begin
        unique case (cur.phase)
          PH_LIT:  state_next.literal_left = cur.literal_left - 8'd1;
          PH_FILL: ;
          default: begin
            if (body_byte < NOOP_CODE) begin
              state_next.literal_left = body_byte + 8'd1;
              state_next.phase        = PH_LIT;
            end else if (body_byte > NOOP_CODE) begin
              state_next.fill_count = 8'(9'd257 - {1'b0, body_byte});
              state_next.phase      = PH_FILL;
            end
          end
        endcase
      end
      state_next.column_pos = col_after;
      if (pkt_end) begin
        state_next.phase = PH_CTRL;
        // row wraps only at a packet boundary
        if (col_after >= cfg.image_width) begin
          state_next.column_pos = '0;
          state_next.row_pos    = row_plus[COORD_W-1:0];
          if (row_plus[COORD_W-1:0] >= cfg.image_height) begin
            state_next.finished = 1'b1;
          end
        end
      end
    end
  end

  // pixel write
  always_comb begin
    pixel.pixel_column = cur.column_pos;
    pixel.pixel_row    = cur.row_pos;
    pixel.pixel_color  = body_byte;
    pixel.run_length   = count;
    pixel.image_done   = (row_plus >= {1'b0, cfg.image_height}) &&
                         (col_end >= {1'b0, cfg.image_width});
    pixel.row_overrun  = overrun;
  end

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for packbits_raster_decoder_unit, byte stream in, pixel writes out
// depends on pbrd_pkg, pbrd_in_if, pbrd_out_if and the decoder rtl; a local decoder model
// predicts every pixel write, random gaps and one long pixel stall stress the handshakes

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pbrd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned STALL_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [BYTE_W-1:0] body_byte;
    logic              image_start;
  } body_item_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pbrd_in_if  body_ch ();
  pbrd_out_if pix_ch ();

  packbits_raster_decoder_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .body      (body_ch),
    .pixels    (pix_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // decoder model state
  logic [COORD_W-1:0] dec_width;
  logic [COORD_W-1:0] dec_height;
  logic               dec_packed;
  phase_t             dec_phase;
  logic [BYTE_W-1:0]  dec_lit_left;
  logic [BYTE_W-1:0]  dec_fill_cnt;
  logic [COORD_W-1:0] dec_col;
  logic [COORD_W-1:0] dec_row;
  logic               dec_finished;

  pixel_t     pixel_expect_q[$];
  body_item_t body_q[$];

  int unsigned bytes_pushed;
  int unsigned bytes_taken;
  int unsigned pixels_checked;
  int unsigned overruns_seen;
  int unsigned images_done_seen;
  int unsigned settings_run;
  int unsigned error_cnt;
  int unsigned cycle_cnt;

  logic stall_req;
  logic stall_done;

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic reset_decoder();
    dec_width    = WIDTH_RESET;
    dec_height   = HEIGHT_RESET;
    dec_packed   = 1'b1;
    dec_phase    = PH_CTRL;
    dec_lit_left = '0;
    dec_fill_cnt = '0;
    dec_col      = '0;
    dec_row      = '0;
    dec_finished = 1'b0;
  endtask

  task automatic emit_pixel(logic [BYTE_W-1:0] color, int unsigned count, logic overrun);
    int unsigned stop;
    pixel_t      px;
    stop = int'(dec_col) + count;
    px.pixel_column = dec_col;
    px.pixel_row    = dec_row;
    px.pixel_color  = color;
    px.run_length   = count[BYTE_W-1:0];
    px.image_done   = ((int'(dec_row) + 1) >= int'(dec_height)) && (stop >= int'(dec_width));
    px.row_overrun  = overrun;
    pixel_expect_q.push_back(px);
    dec_col = stop[COORD_W-1:0];
  endtask

  // rows only wrap at a packet boundary
  task automatic close_packet();
    dec_phase = PH_CTRL;
    if (dec_col >= dec_width) begin
      dec_col = '0;
      dec_row = dec_row + 1'b1;
      if (dec_row >= dec_height) dec_finished = 1'b1;
    end
  endtask

  task automatic decode_byte(logic [BYTE_W-1:0] b, logic start);
    int unsigned room;
    int unsigned cnt;
    if (start) begin
      dec_col      = '0;
      dec_row      = '0;
      dec_phase    = PH_CTRL;
      dec_lit_left = '0;
      dec_fill_cnt = '0;
      dec_finished = 1'b0;
    end
    if (dec_finished || dec_row >= dec_height) begin
      dec_finished = 1'b1;
    end else if (!dec_packed) begin
      dec_phase = PH_CTRL;
      if (dec_col < dec_width) emit_pixel(b, 1, 1'b0);
      close_packet();
    end else begin
      case (dec_phase)
        PH_LIT: begin
          if (dec_col < dec_width) emit_pixel(b, 1, 1'b0);
          dec_lit_left = dec_lit_left - 1'b1;
          if (dec_lit_left == 0) close_packet();
        end
        PH_FILL: begin
          room = (dec_col < dec_width) ? int'(dec_width) - int'(dec_col) : 0;
          cnt  = (int'(dec_fill_cnt) < room) ? int'(dec_fill_cnt) : room;
          if (cnt > 0) emit_pixel(b, cnt, cnt < int'(dec_fill_cnt));
          close_packet();
        end
        default: begin
          if (b < NOOP_CODE) begin
            dec_lit_left = b + 1'b1;
            dec_phase    = PH_LIT;
          end else if (b > NOOP_CODE) begin
            cnt          = 257 - int'(b);
            dec_fill_cnt = cnt[BYTE_W-1:0];
            dec_phase    = PH_FILL;
          end else begin
            close_packet();
          end
        end
      endcase
    end
  endtask

  task automatic report_field(string name, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: pixel %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_cnt++;
    end
  endtask

  // body driver
  int unsigned in_gap;
  int unsigned in_calm;
  body_item_t  drv_item;

  always @(posedge clk) begin
    if (rst) begin
      body_ch.valid       <= 1'b0;
      body_ch.body_byte   <= '0;
      body_ch.image_start <= 1'b0;
      in_gap  = 0;
      in_calm = 0;
    end else if (body_ch.valid && !body_ch.ready) begin
      // hold the offered byte
    end else if (in_gap != 0) begin
      in_gap--;
      body_ch.valid <= 1'b0;
    end else if (body_q.size() != 0) begin
      drv_item = body_q.pop_front();
      body_ch.valid       <= 1'b1;
      body_ch.body_byte   <= drv_item.body_byte;
      body_ch.image_start <= drv_item.image_start;
      if (in_calm != 0) in_calm--;
      else if ($urandom_range(0, 63) == 0) in_calm = $urandom_range(50, 150);
      else if ($urandom_range(0, 4) == 0) in_gap = pick_gap();
    end else begin
      body_ch.valid <= 1'b0;
    end
  end

  // pixel sink ready, with one long hold-off on request
  int unsigned out_gap;
  int unsigned out_calm;
  int unsigned out_hold;

  always @(posedge clk) begin
    if (rst) begin
      pix_ch.ready <= 1'b0;
      out_gap  = 0;
      out_calm = 0;
      out_hold = 0;
    end else if (out_hold != 0) begin
      out_hold--;
      pix_ch.ready <= 1'b0;
    end else if (stall_req && !stall_done) begin
      stall_done = 1'b1;
      out_hold   = STALL_CYCLES;
      pix_ch.ready <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap--;
      pix_ch.ready <= 1'b0;
    end else begin
      pix_ch.ready <= 1'b1;
      if (out_calm != 0) out_calm--;
      else if ($urandom_range(0, 63) == 0) out_calm = $urandom_range(50, 150);
      else if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
    end
  end

  // monitor: register writes, byte transactions into the model, pixel transactions checked
  pixel_t want_px;
  pixel_t got_px;

  always @(posedge clk) begin
    if (rst) begin
      reset_decoder();
      pixel_expect_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  dec_width  = cfg_data;
          CFG_IMAGE_HEIGHT: dec_height = cfg_data;
          CFG_PACKED_MODE:  dec_packed = cfg_data[0];
          default: ;
        endcase
      end
      if (body_ch.valid && body_ch.ready) begin
        decode_byte(body_ch.body_byte, body_ch.image_start);
        bytes_taken++;
      end
      if (pix_ch.valid && pix_ch.ready) begin
        got_px.pixel_column = pix_ch.pixel_column;
        got_px.pixel_row    = pix_ch.pixel_row;
        got_px.pixel_color  = pix_ch.pixel_color;
        got_px.run_length   = pix_ch.run_length;
        got_px.image_done   = pix_ch.image_done;
        got_px.row_overrun  = pix_ch.row_overrun;
        if (pixel_expect_q.size() == 0) begin
          $display("%0t: unexpected pixel write, expected none, actual col %0d row %0d color %0d",
                   $time, got_px.pixel_column, got_px.pixel_row, got_px.pixel_color);
          error_cnt++;
        end else begin
          want_px = pixel_expect_q.pop_front();
          report_field("column", want_px.pixel_column, got_px.pixel_column);
          report_field("row", want_px.pixel_row, got_px.pixel_row);
          report_field("color", want_px.pixel_color, got_px.pixel_color);
          report_field("run_length", want_px.run_length, got_px.run_length);
          report_field("image_done", want_px.image_done, got_px.image_done);
          report_field("row_overrun", want_px.row_overrun, got_px.row_overrun);
          pixels_checked++;
          if (got_px.row_overrun) overruns_seen++;
          if (got_px.image_done) images_done_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d bytes taken", cycle_cnt, bytes_taken,
               bytes_pushed);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_body(int unsigned b, logic start);
    body_item_t it;
    it.body_byte   = b[BYTE_W-1:0];
    it.image_start = start;
    body_q.push_back(it);
    bytes_pushed++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // block idle: every byte taken, every pixel write seen, plus a short drain
  task automatic wait_idle();
    do @(negedge clk); while (!(bytes_taken == bytes_pushed && pixel_expect_q.size() == 0));
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // packed: mostly well-formed packets with random content, some broken packets and noise; raw: random bytes
  task automatic gen_stream(int unsigned count, int unsigned every, logic pk, logic restart);
    int unsigned left;
    int unsigned pkts;
    int unsigned r;
    int unsigned n;
    int unsigned i;
    logic        start_next;
    left       = count;
    pkts       = 0;
    start_next = restart;
    while (left != 0) begin
      if (!pk) begin
        push_body($urandom_range(0, 255), start_next || ($urandom_range(1, every) == 1));
        start_next = 1'b0;
        left--;
      end else begin
        pkts++;
        if (pkts % every == 0) start_next = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 45) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
          push_body(n, start_next);
          start_next = 1'b0;
          left--;
          for (i = 0; i <= n && left != 0; i++) begin
            // cut the packet short with a new image
            if ($urandom_range(0, 49) == 0) begin
              start_next = 1'b1;
              break;
            end
            push_body($urandom_range(0, 255), 1'b0);
            left--;
          end
        end else if (r < 85) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(129, 255)
                                          : 257 - $urandom_range(2, 6);
          push_body(n, start_next);
          start_next = 1'b0;
          left--;
          if (left != 0) begin
            push_body($urandom_range(0, 255), 1'b0);
            left--;
          end
        end else if (r < 90) begin
          push_body(NOOP_CODE, start_next);
          start_next = 1'b0;
          left--;
        end else begin
          push_body($urandom_range(0, 255), $urandom_range(0, 1));
          start_next = 1'b0;
          left--;
        end
      end
    end
  endtask

  task automatic run_setting(int unsigned w, int unsigned h, logic pk, int unsigned every,
                             int unsigned count, logic restart);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_PACKED_MODE, pk);
    gen_stream(count, every, pk, restart);
    settings_run++;
    wait_idle();
  endtask

  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    cfg_write           = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    body_ch.valid       = 1'b0;
    body_ch.body_byte   = '0;
    body_ch.image_start = 1'b0;
    pix_ch.ready        = 1'b0;
    stall_req           = 1'b0;
    stall_done          = 1'b0;
    bytes_pushed        = 0;
    bytes_taken         = 0;
    pixels_checked      = 0;
    overruns_seen       = 0;
    images_done_seen    = 0;
    settings_run        = 0;
    error_cnt           = 0;
    cycle_cnt           = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: tiny 4x2 packed image
    write_reg(CFG_IMAGE_WIDTH, 4);
    write_reg(CFG_IMAGE_HEIGHT, 2);
    write_reg(CFG_PACKED_MODE, 1);
    push_body(8'h00, 1'b1);  // one literal
    push_body(8'h00, 1'b0);
    push_body(NOOP_CODE, 1'b0);
    push_body(8'hFF, 1'b0);  // shortest fill
    push_body(8'hAA, 1'b0);
    push_body(8'h81, 1'b0);  // longest fill, clipped at the row end
    push_body(8'h55, 1'b0);
    push_body(8'h01, 1'b0);
    push_body(8'h12, 1'b0);
    push_body(8'h34, 1'b0);
    push_body(8'h03, 1'b0);  // literals running past the row end
    push_body(8'h01, 1'b0);
    push_body(8'h02, 1'b0);
    push_body(8'h03, 1'b0);
    push_body(8'h04, 1'b0);
    push_body(8'h7F, 1'b0);  // after the last row, ignored
    push_body(8'hFE, 1'b1);  // new image
    push_body(8'hFF, 1'b0);
    push_body(NOOP_CODE, 1'b0);
    push_body(8'h7F, 1'b0);  // longest literal, left open for the mode change
    settings_run++;
    wait_idle();

    run_setting(13, 4, 1'b0, 40, 80, 1'b0);
    stall_req = 1'b1;
    run_setting(WIDTH_RESET, HEIGHT_RESET, 1'b1, 1000, 100, 1'b1);
    run_setting(1, 1, 1'b1, 2, 60, 1'b1);
    run_setting(65535, 65535, 1'b1, 100000, 80, 1'b1);
    run_setting(5, 2, 1'b1, 5, 100, 1'b0);  // width shrinks under an open row
    run_setting(65535, 1, 1'b0, 200, 60, 1'b1);
    run_setting(3, 65535, 1'b1, 50, 60, 1'b1);
    run_setting(2, 6, 1'b1, 6, 60, 1'b1);
    run_setting(9, 3, 1'b0, 20, 40, 1'b0);
    run_setting(4, 3, 1'b1, 4, 60, 1'b1);

    repeat (20) @(negedge clk);
    if (pixel_expect_q.size() != 0) begin
      $display("%0t: %0d expected pixel writes never arrived, expected 0, actual %0d", $time,
               pixel_expect_q.size(), pixel_expect_q.size());
      error_cnt++;
    end
    $display("ran %0d body bytes over %0d register settings, packed and raw, one long stall",
             bytes_taken, settings_run);
    $display("checked %0d pixel writes: %0d clipped fills, %0d completed images, %0d errors",
             pixels_checked, overruns_seen, images_done_seen, error_cnt);
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== packbits_raster_decoder_unit.f =====
src/pbrd_pkg.sv
src/pbrd_if.sv
src/pbrd_step.sv
src/packbits_raster_decoder_unit.sv
test/tb_top.sv
